// ===== src/sszcf_pkg.sv =====
// shared types and constants of the sub-window schmitt zero-cross frequency estimator
// no dependencies; imported by sszcf_alu and the top module
package sszcf_pkg;

  typedef struct packed {
    logic [11:0] sample;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [25:0] freq_q8;
    logic [10:0] cross_count;
    logic [2:0]  good_windows;
    logic [11:0] max_peak_to_peak;
    logic [19:0] max_std_q8;
  } result_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PKPK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STD     = 2'd2;

  localparam logic [18:0] RST_SAMPLE_RATE = 19'd100000;
  localparam logic [11:0] RST_MIN_PKPK    = 12'd100;
  localparam logic [19:0] RST_MIN_STD     = 20'd2560;

  // arithmetic unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

endpackage

// ===== src/sszcf_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing
module sszcf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sszcf_alu.sv =====
// iterative arithmetic unit: shift-add multiply, restoring divide, digit square root
// depends on sszcf_pkg for operation codes and the control struct
module sszcf_alu import sszcf_pkg::*; #(
  parameter int W = 62
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_ctl_t     ctl,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int NW = $clog2(W + 1);

  logic          busy;
  logic [1:0]    op;
  logic [NW-1:0] step;
  logic [W-1:0]  acc;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W+1:0]  rem;
  logic [W+1:0]  rem_div;
  logic [W+1:0]  rem_sq;
  logic [W+1:0]  trial_sq;
  logic [NW-1:0] last_step;

  assign rem_div   = {rem[W:0], x[W-1]};
  assign rem_sq    = {rem[W-1:0], x[W-1:W-2]};
  assign trial_sq  = {acc, 2'b01};
  assign last_step = (op == OP_SQRT) ? NW'(W / 2 - 1) : NW'(W - 1);
  assign res       = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        step <= '0;
        acc  <= '0;
        rem  <= '0;
        x    <= a;
        y    <= b;
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            if (y[0]) begin
              acc <= acc + x;
            end
            x <= x << 1;
            y <= y >> 1;
          end
          OP_DIV: begin
            if (rem_div >= {2'b00, y}) begin
              rem <= rem_div - {2'b00, y};
              acc <= {acc[W-2:0], 1'b1};
            end else begin
              rem <= rem_div;
              acc <= {acc[W-2:0], 1'b0};
            end
            x <= x << 1;
          end
          OP_SQRT: begin
            if (rem_sq >= trial_sq) begin
              rem <= rem_sq - trial_sq;
              acc <= {acc[W-2:0], 1'b1};
            end else begin
              rem <= rem_sq;
              acc <= {acc[W-2:0], 1'b0};
            end
            x <= x << 2;
          end
          default: begin
            acc <= '0;
          end
        endcase
        step <= step + 1'b1;
        if (step == last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/subwindow_schmitt_zero_cross_freq.sv =====
// capture loading, per-sub-window statistics, schmitt crossing count, frequency estimate
// depends on sszcf_pkg, sszcf_ram (sample store) and sszcf_alu (shared mul/div/sqrt)
// load: one sample transfer per cycle, item stall stays low while the capture is collected
// analysis after the last sample is paced by the single sample ram read port and the
//   bit-serial alu of width LW (LW = 62 at the default parameters)
// the result register frees the input side: loading goes on while a result waits for transfer
// reset (rst, synchronous): empty capture, registers to their defaults, no result pending
module subwindow_schmitt_zero_cross_freq import sszcf_pkg::*; #(
  parameter int SUBWINDOWS  = 4,
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SW    = CW + SB;
  localparam int QW    = CW + 2 * SB;
  localparam int DW    = CW + QW;
  localparam int XW    = DW + 16;
  localparam int LW    = XW + (XW % 2);
  localparam int SQW   = LW / 2;
  localparam int WNW   = $clog2(SUBWINDOWS + 1);
  localparam int PW    = $clog2(SUBWINDOWS);
  localparam int MIN_N = 4 * SUBWINDOWS;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BLK  = 4'd1;
  localparam logic [3:0] S_B2   = 4'd2;
  localparam logic [3:0] S_WIN  = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_PK   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_DV   = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_P2   = 4'd10;
  localparam logic [3:0] S_NEXT = 4'd11;
  localparam logic [3:0] S_FRQ  = 4'd12;
  localparam logic [3:0] S_FM   = 4'd13;
  localparam logic [3:0] S_FD   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]     state;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic [CW-1:0]  n;
  logic [CW-1:0]  blk;
  logic [PW-1:0]  blk_phase;
  logic [CW-1:0]  blk_cnt;
  logic [CW-1:0]  blk_cnt_next;
  logic           phase_wrap;
  logic [LW-1:0]  b2;
  logic [CW-1:0]  base;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  rd_pos;
  logic [WNW-1:0] win;
  logic [WNW-1:0] active;
  logic [SB-1:0]  mn;
  logic [SB-1:0]  mx;
  logic [SB-1:0]  pk;
  logic [SW-1:0]  sum;
  logic [QW-1:0]  sumsq;
  logic [2*SB-1:0] sq;
  logic           rv1;
  logic           rv2;
  logic           first;
  logic [LW-1:0]  t1;
  logic [SB-1:0]  max_pk;
  logic [SQW-1:0] max_std;
  logic [CW-1:0]  total;
  logic           trig;
  logic [SB:0]    mid;
  logic [SB:0]    up;
  logic [SB:0]    dn;
  logic [LW-1:0]  freq;
  logic [18:0]    sample_rate;
  logic [11:0]    min_pkpk;
  logic [19:0]    min_std;

  // sample ram
  logic           ram_we;
  logic           ram_re;
  logic [SB-1:0]  ram_rdata;
  logic [SB:0]    vx;

  // shared arithmetic unit
  alu_ctl_t       alu_ctl;
  logic           alu_pend;
  logic           alu_state;
  logic           alu_done;
  logic [LW-1:0]  alu_a;
  logic [LW-1:0]  alu_b;
  logic [LW-1:0]  alu_res;

  logic           in_xfer;
  logic           issue;

  assign cfg_ready  = (state == S_IDLE);
  assign item_stall = (state != S_IDLE);
  assign in_xfer    = item_valid && !item_stall;
  assign ram_we     = in_xfer && (cnt < CW'(MAX_SAMPLES));
  assign cnt_next   = (cnt < CW'(MAX_SAMPLES)) ? cnt + 1'b1 : cnt;
  // sub-window length kept as a running quotient of the stored sample count
  assign phase_wrap   = ram_we && (blk_phase == PW'(SUBWINDOWS - 1));
  assign blk_cnt_next = phase_wrap ? blk_cnt + 1'b1 : blk_cnt;
  assign issue      = ((state == S_P1) || (state == S_P2)) && (idx < blk);
  assign ram_re     = issue;
  assign rd_pos     = base + idx;
  assign vx         = {1'b0, ram_rdata};
  assign pk         = mx - mn;

  sszcf_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(SB'(item.sample)),
    .re   (ram_re),
    .raddr(rd_pos[AW-1:0]),
    .rdata(ram_rdata)
  );

  // operand selection for the alu, one operation per state
  always_comb begin
    alu_state = (state inside {S_B2, S_M1, S_M2, S_DV, S_SQ, S_FM, S_FD});
    alu_ctl.start = alu_state && !alu_pend;
    alu_ctl.op = OP_MUL;
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_B2: begin
        alu_a = LW'(blk);
        alu_b = LW'(blk);
      end
      S_M1: begin
        alu_a = LW'(blk);
        alu_b = LW'(sumsq);
      end
      S_M2: begin
        alu_a = LW'(sum);
        alu_b = LW'(sum);
      end
      S_DV: begin
        // variance scaled by 2^16 over blk^2
        alu_ctl.op = OP_DIV;
        alu_a = t1 << 16;
        alu_b = b2;
      end
      S_SQ: begin
        alu_ctl.op = OP_SQRT;
        alu_a = t1;
      end
      S_FM: begin
        alu_a = LW'(total);
        alu_b = LW'(sample_rate);
      end
      S_FD: begin
        // crossings*rate/(2n) in q8 is crossings*rate*128/n
        alu_ctl.op = OP_DIV;
        alu_a = t1 << 7;
        alu_b = LW'(n);
      end
      default: begin
        alu_ctl.op = OP_MUL;
      end
    endcase
  end

  sszcf_alu #(
    .W(LW)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .done(alu_done),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      blk_phase    <= '0;
      blk_cnt      <= '0;
      alu_pend     <= 1'b0;
      rv1          <= 1'b0;
      rv2          <= 1'b0;
      result_valid <= 1'b0;
      sample_rate  <= RST_SAMPLE_RATE;
      min_pkpk     <= RST_MIN_PKPK;
      min_std      <= RST_MIN_STD;
    end else begin
      // configuration writes, only while idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_RATE: sample_rate <= cfg_data[18:0];
          REG_MIN_PKPK:    min_pkpk    <= cfg_data[11:0];
          REG_MIN_STD:     min_std     <= cfg_data;
          default: begin
          end
        endcase
      end

      // a new result in the done state refills the register itself
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      if (alu_ctl.start) begin
        alu_pend <= 1'b1;
      end else if (alu_done) begin
        alu_pend <= 1'b0;
      end

      rv1 <= issue;
      rv2 <= rv1 && (state == S_P1);
      if (issue) begin
        idx <= idx + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (item.last) begin
              // capture closed: latch its length and clear the summary
              n         <= cnt_next;
              blk       <= blk_cnt_next;
              cnt       <= '0;
              blk_cnt   <= '0;
              blk_phase <= '0;
              total     <= '0;
              active    <= '0;
              max_pk    <= '0;
              max_std   <= '0;
              freq      <= '0;
              base      <= '0;
              win       <= '0;
              state     <= S_BLK;
            end else begin
              cnt     <= cnt_next;
              blk_cnt <= blk_cnt_next;
              if (ram_we) begin
                blk_phase <= phase_wrap ? '0 : blk_phase + 1'b1;
              end
            end
          end
        end
        S_BLK: begin
          // short capture reports all zero
          if (n < CW'(MIN_N)) begin
            state <= S_DONE;
          end else begin
            state <= S_B2;
          end
        end
        S_B2: begin
          if (alu_done) begin
            b2    <= alu_res;
            state <= S_WIN;
          end
        end
        S_WIN: begin
          idx   <= '0;
          first <= 1'b1;
          sum   <= '0;
          sumsq <= '0;
          state <= S_P1;
        end
        S_P1: begin
          // stage one: min, max, sum and square; stage two: sum of squares
          if (rv1) begin
            if (first) begin
              mn    <= ram_rdata;
              mx    <= ram_rdata;
              first <= 1'b0;
            end else begin
              if (ram_rdata < mn) mn <= ram_rdata;
              if (ram_rdata > mx) mx <= ram_rdata;
            end
            sum <= sum + SW'(ram_rdata);
            sq  <= ram_rdata * ram_rdata;
          end
          if (rv2) begin
            sumsq <= sumsq + QW'(sq);
          end
          if (!issue && !rv1 && !rv2) begin
            state <= S_PK;
          end
        end
        S_PK: begin
          if (pk > max_pk) begin
            max_pk <= pk;
          end
          mid <= ({1'b0, mn} + {1'b0, mx}) >> 1;
          if (LW'(pk) < LW'(min_pkpk)) begin
            state <= S_NEXT;
          end else begin
            state <= S_M1;
          end
        end
        S_M1: begin
          up <= mid + (SB + 1)'(pk >> 2);
          dn <= mid - (SB + 1)'(pk >> 2);
          if (alu_done) begin
            t1    <= alu_res;
            state <= S_M2;
          end
        end
        S_M2: begin
          if (alu_done) begin
            t1    <= t1 - alu_res;
            state <= S_DV;
          end
        end
        S_DV: begin
          if (alu_done) begin
            t1    <= alu_res;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (alu_done) begin
            if (alu_res[SQW-1:0] > max_std) begin
              max_std <= alu_res[SQW-1:0];
            end
            if (LW'(alu_res[SQW-1:0]) < LW'(min_std)) begin
              state <= S_NEXT;
            end else begin
              active <= active + 1'b1;
              idx    <= '0;
              first  <= 1'b1;
              state  <= S_P2;
            end
          end
        end
        S_P2: begin
          // schmitt trigger walk over the sub-window
          if (rv1) begin
            if (first) begin
              trig  <= (vx > mid);
              first <= 1'b0;
            end else if (trig && (vx < dn)) begin
              trig  <= 1'b0;
              total <= total + 1'b1;
            end else if (!trig && (vx > up)) begin
              trig  <= 1'b1;
              total <= total + 1'b1;
            end
          end
          if (!issue && !rv1) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          win  <= win + 1'b1;
          base <= base + blk;
          if (win == WNW'(SUBWINDOWS - 1)) begin
            state <= S_FRQ;
          end else begin
            state <= S_WIN;
          end
        end
        S_FRQ: begin
          if ((active >= WNW'(2)) && (total >= CW'(2))) begin
            state <= S_FM;
          end else begin
            state <= S_DONE;
          end
        end
        S_FM: begin
          if (alu_done) begin
            t1    <= alu_res;
            state <= S_FD;
          end
        end
        S_FD: begin
          if (alu_done) begin
            freq  <= alu_res;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hand over once the result register is free
          if (!result_valid || !result_stall) begin
            result.freq_q8          <= 26'(freq);
            result.cross_count      <= 11'(total);
            result.good_windows     <= 3'(active);
            result.max_peak_to_peak <= 12'(max_pk);
            result.max_std_q8       <= 20'(max_std);
            result_valid            <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SAMPLES))
    else $error("capture count past buffer size");

  a_no_math_while_loading: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !alu_pend)
    else $error("arithmetic unit busy while capture is loading");

  a_done_when_pending: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> alu_pend)
    else $error("arithmetic result without a pending request");

  a_store_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (state == S_IDLE) || (state == S_BLK))
    else $error("sample store written during analysis");

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ({1'b0, active} <= (WNW + 1)'(SUBWINDOWS)))
    else $error("more active sub-windows than sub-windows");
`endif

endmodule
